[rtl/ocpu_pkg.sv]
`default_nettype none
package ocpu_pkg;

  localparam int MemBits    = 512;
  localparam int MemAw      = $clog2(MemBits);
  localparam int OutLimit   = 512;
  localparam int StackDepth = 16;
  localparam int StAw       = $clog2(StackDepth);
  localparam int PtrBits    = 16;

  // Opcodes of the decoded instruction.
  localparam logic [4:0] OpMovCr    = 5'd0;
  localparam logic [4:0] OpMovCm    = 5'd1;
  localparam logic [4:0] OpFill     = 5'd2;
  localparam logic [4:0] OpMovMr    = 5'd3;
  localparam logic [4:0] OpMovRm    = 5'd4;
  localparam logic [4:0] OpMovMm    = 5'd5;
  localparam logic [4:0] OpCopy     = 5'd6;
  localparam logic [4:0] OpMovRr    = 5'd7;
  localparam logic [4:0] OpJmp      = 5'd8;
  localparam logic [4:0] OpJmpZ     = 5'd9;
  localparam logic [4:0] OpJmpNz    = 5'd10;
  localparam logic [4:0] OpJmpR     = 5'd11;
  localparam logic [4:0] OpJmpRz    = 5'd12;
  localparam logic [4:0] OpJmpRnz   = 5'd13;
  localparam logic [4:0] OpAndC     = 5'd14;
  localparam logic [4:0] OpAndR     = 5'd15;
  localparam logic [4:0] OpOrC      = 5'd16;
  localparam logic [4:0] OpOrR      = 5'd17;
  localparam logic [4:0] OpNot      = 5'd18;
  localparam logic [4:0] OpSwap     = 5'd19;
  localparam logic [4:0] OpOutA     = 5'd20;
  localparam logic [4:0] OpOutMem   = 5'd21;
  localparam logic [4:0] OpOutRange = 5'd22;
  localparam logic [4:0] OpPrint    = 5'd23;
  localparam logic [4:0] OpHalt     = 5'd24;
  localparam logic [4:0] OpInA      = 5'd25;
  localparam logic [4:0] OpInMem    = 5'd26;
  localparam logic [4:0] OpCall     = 5'd27;
  localparam logic [4:0] OpRet      = 5'd28;

  // Fault codes.
  localparam logic [3:0] ErrNone     = 4'd0;
  localparam logic [3:0] ErrPtr      = 4'd1;
  localparam logic [3:0] ErrAddr     = 4'd2;
  localparam logic [3:0] ErrReversed = 4'd3;
  localparam logic [3:0] ErrLength   = 4'd4;
  localparam logic [3:0] ErrOverflow = 4'd5;
  localparam logic [3:0] ErrStackOvf = 4'd6;
  localparam logic [3:0] ErrStackEmp = 4'd7;
  localparam logic [3:0] ErrUnknown  = 4'd8;

  // Access request to the bit memory.
  typedef struct packed {
    logic             rd_en;
    logic [MemAw-1:0] rd_addr;
    logic             wr_en;
    logic [MemAw-1:0] wr_addr;
    logic             wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

[rtl/ocpu_bitmem.sv]
`default_nettype none
module ocpu_bitmem import ocpu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mem_req_t req_i,
  output logic          rd_data_o,
  output logic          busy_o
);

  logic             mem [MemBits];
  logic [MemAw:0]   clr_q;
  logic [MemAw:0]   clr_d;
  logic             rd_q;

  // The clearing pass walks every entry once after reset.
  assign busy_o = ~clr_q[MemAw];
  assign clr_d  = clr_q + (MemAw+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_d;
    end
  end

  // Single write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem[clr_q[MemAw-1:0]] <= 1'b0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

[rtl/one_bit_cpu_execute.sv]
// Each instruction goes from accept through the execute state to the done state, which
// hands the result to the output register; single reads and return add a use state,
// range copy and range out alternate use and read states for each bit, and fills step
// through a fill state for each bit. One instruction is in flight at a time, so a word
// is accepted only in the idle state; a new word is taken while a result waits.
// Reset clears all machine state; a clearing pass then zeroes every entry of the
// bit memory, during which no instruction word is accepted.
`default_nettype none
module one_bit_cpu_execute import ocpu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type, src_sel, dst_sel, const_bit, first_lo, first_hi, second_lo,
  // second_hi, jump_target, jump_offset, input_bit, zero pad
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_ip, halted, error_code, printed, print_value, print_count
  output logic [95:0]      m_axis_tdata
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StFill = 3'd2;
  localparam logic [2:0] StRdn  = 3'd3;
  localparam logic [2:0] StUse  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [4:0]  op_q;
  logic [1:0]  src_q, dst_q;
  logic        cb_q, ib_q;
  logic [9:0]  f1_q, f2_q, s1_q, s2_q;
  logic [15:0] tgt_q, off_q;
  logic [2:0]  abc_q, abc_d;
  logic [PtrBits-1:0] ptr_q, ptr_d;
  logic        pinv_q, pinv_d;
  logic [63:0] oshift_q, oshift_d;
  logic [9:0]  ocnt_q, ocnt_d;
  logic [StAw:0] lvl_q, lvl_d;
  logic        stop_q, stop_d;
  logic [3:0]  fault_q, fault_d;
  logic [15:0] plen_q;
  logic [MemAw-1:0] cur_q, cur_d, dcur_q, dcur_d;
  logic        pr_q, pr_d;
  logic [63:0] pval_q, pval_d;
  logic [9:0]  pcnt_q, pcnt_d;
  logic        mvalid_q, mvalid_d;
  logic [95:0] mdata_q, mdata_d;

  logic [PtrBits-1:0] stk_mem [StackDepth];
  logic [PtrBits-1:0] stk_rdata_q;
  logic        st_we, st_re;
  logic [StAw-1:0] st_waddr, st_raddr;

  mem_req_t    mreq;
  logic        mrd;
  logic        clr_busy;
  logic        accept;

  logic        f1_bad, f2_bad, s1_bad, s2_bad, ptr_bad;
  logic [3:0]  err;
  logic [10:0] out_need;
  logic [PtrBits:0]   inc_sum;
  logic [PtrBits+1:0] rel_sum;
  logic [PtrBits:0]   ret_sum;
  logic [PtrBits-1:0] nxt_ptr;
  logic        nxt_inv;
  logic        src_v, dst_v, src_ok;

  function automatic logic get_bit(logic [2:0] abc, logic [1:0] sel);
    get_bit = (sel == 2'd3) ? 1'b0 : abc[sel];
  endfunction

  function automatic logic [2:0] put_bit(logic [2:0] abc, logic [1:0] sel, logic v);
    logic [2:0] r;
    r = abc;
    if (sel != 2'd3) r[sel] = v;
    put_bit = r;
  endfunction

  ocpu_bitmem u_bitmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .rd_data_o (mrd),
    .busy_o    (clr_busy)
  );

  assign s_axis_tready = (state_q == StIdle) && !clr_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  // Operand checks on the latched word.
  assign f1_bad  = f1_q >= 10'(MemBits);
  assign f2_bad  = f2_q >= 10'(MemBits);
  assign s1_bad  = s1_q >= 10'(MemBits);
  assign s2_bad  = s2_q >= 10'(MemBits);
  assign ptr_bad = pinv_q || (ptr_q >= plen_q);
  assign out_need = {1'b0, ocnt_q} + {1'b0, f2_q - f1_q} + 11'd1;
  assign src_v   = get_bit(abc_q, src_q);
  assign dst_v   = get_bit(abc_q, dst_q);
  assign src_ok  = src_q != 2'd3;

  always_comb begin
    err = ErrNone;
    case (op_q)
      OpMovCm, OpMovMr, OpMovRm, OpInMem: if (f1_bad) err = ErrAddr;
      OpFill: if (f1_bad || f2_bad) err = ErrAddr;
      OpMovMm: if (f1_bad || s1_bad) err = ErrAddr;
      OpCopy: begin
        if (f1_bad || f2_bad || s1_bad || s2_bad) err = ErrAddr;
        else if (f1_q > f2_q || s1_q > s2_q) err = ErrReversed;
        else if ((f2_q - f1_q) != (s2_q - s1_q)) err = ErrLength;
      end
      OpOutA: if (ocnt_q >= 10'(OutLimit)) err = ErrOverflow;
      OpOutMem: begin
        if (ocnt_q >= 10'(OutLimit)) err = ErrOverflow;
        else if (f1_bad) err = ErrAddr;
      end
      OpOutRange: begin
        if (f1_bad || f2_bad) err = ErrAddr;
        else if (f1_q > f2_q) err = ErrReversed;
        else if (out_need > 11'(OutLimit)) err = ErrOverflow;
      end
      OpCall: if (lvl_q >= (StAw+1)'(StackDepth)) err = ErrStackOvf;
      OpRet: if (lvl_q == '0) err = ErrStackEmp;
      OpMovCr, OpMovRr, OpJmp, OpJmpZ, OpJmpNz, OpJmpR, OpJmpRz, OpJmpRnz,
      OpAndC, OpAndR, OpOrC, OpOrR, OpNot, OpSwap, OpPrint, OpHalt, OpInA: err = ErrNone;
      default: err = ErrUnknown;
    endcase
  end

  // Next pointer: increment, absolute or relative jump.
  assign inc_sum = {1'b0, ptr_q} + (PtrBits+1)'(1);
  assign rel_sum = {2'b00, ptr_q} + {{2{off_q[15]}}, off_q};
  assign ret_sum = {1'b0, stk_rdata_q} + (PtrBits+1)'(1);

  always_comb begin
    nxt_ptr = inc_sum[PtrBits-1:0];
    nxt_inv = inc_sum[PtrBits];
    case (op_q)
      OpJmp, OpCall: begin
        nxt_ptr = tgt_q;
        nxt_inv = 1'b0;
      end
      OpJmpZ, OpJmpNz: begin
        if (src_ok && (src_v == (op_q == OpJmpNz))) begin
          nxt_ptr = tgt_q;
          nxt_inv = 1'b0;
        end
      end
      OpJmpR: begin
        nxt_ptr = rel_sum[PtrBits-1:0];
        nxt_inv = rel_sum[PtrBits+1] | rel_sum[PtrBits];
      end
      OpJmpRz, OpJmpRnz: begin
        if (src_ok && (src_v == (op_q == OpJmpRnz))) begin
          nxt_ptr = rel_sum[PtrBits-1:0];
          nxt_inv = rel_sum[PtrBits+1] | rel_sum[PtrBits];
        end
      end
      default: ;
    endcase
  end

  // Sequencer: check, execute, walk memory, deliver.
  always_comb begin
    state_d  = state_q;
    abc_d    = abc_q;
    ptr_d    = ptr_q;
    pinv_d   = pinv_q;
    oshift_d = oshift_q;
    ocnt_d   = ocnt_q;
    lvl_d    = lvl_q;
    stop_d   = stop_q;
    fault_d  = fault_q;
    cur_d    = cur_q;
    dcur_d   = dcur_q;
    pr_d     = pr_q;
    pval_d   = pval_q;
    pcnt_d   = pcnt_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;
    mreq     = '0;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_waddr = lvl_q[StAw-1:0];
    st_raddr = StAw'(lvl_q - (StAw+1)'(1));

    if (mvalid_q && m_axis_tready) mvalid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
          pr_d    = 1'b0;
          pval_d  = '0;
          pcnt_d  = '0;
        end
      end
      StExec: begin
        state_d = StDone;
        if (stop_q) begin
          state_d = StDone;
        end else if (ptr_bad) begin
          stop_d  = 1'b1;
          fault_d = ErrPtr;
        end else if (err != ErrNone) begin
          stop_d  = 1'b1;
          fault_d = err;
        end else begin
          ptr_d  = nxt_ptr;
          pinv_d = nxt_inv;
          case (op_q)
            OpMovCr: abc_d = put_bit(abc_q, dst_q, cb_q);
            OpMovRr: abc_d = put_bit(abc_q, dst_q, src_v);
            OpAndC:  abc_d[0] = abc_q[0] & cb_q;
            OpAndR:  abc_d[0] = abc_q[0] & src_v;
            OpOrC:   abc_d[0] = abc_q[0] | cb_q;
            OpOrR:   abc_d[0] = abc_q[0] | src_v;
            OpNot:   abc_d[0] = ~abc_q[0];
            OpSwap:  abc_d = put_bit(put_bit(abc_q, src_q, dst_v), dst_q, src_v);
            OpInA:   abc_d[0] = ib_q;
            OpMovCm, OpInMem, OpMovRm: begin
              mreq.wr_en   = 1'b1;
              mreq.wr_addr = f1_q[MemAw-1:0];
              mreq.wr_data = (op_q == OpMovCm) ? cb_q :
                             (op_q == OpInMem) ? ib_q : src_v;
            end
            OpFill: begin
              if (f1_q <= f2_q) begin
                cur_d   = f1_q[MemAw-1:0];
                state_d = StFill;
              end
            end
            OpMovMr, OpOutMem, OpMovMm, OpCopy, OpOutRange: begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = f1_q[MemAw-1:0];
              cur_d        = f1_q[MemAw-1:0];
              dcur_d       = s1_q[MemAw-1:0];
              state_d      = StUse;
            end
            OpOutA: begin
              oshift_d = {oshift_q[62:0], abc_q[0]};
              ocnt_d   = ocnt_q + 10'd1;
            end
            OpPrint: begin
              pr_d     = 1'b1;
              pval_d   = oshift_q;
              pcnt_d   = ocnt_q;
              oshift_d = '0;
              ocnt_d   = '0;
            end
            OpHalt: begin
              stop_d  = 1'b1;
              fault_d = ErrNone;
            end
            OpCall: begin
              st_we = 1'b1;
              lvl_d = lvl_q + (StAw+1)'(1);
            end
            OpRet: begin
              st_re   = 1'b1;
              lvl_d   = lvl_q - (StAw+1)'(1);
              state_d = StUse;
            end
            default: ;
          endcase
        end
      end
      StFill: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = cur_q;
        mreq.wr_data = cb_q;
        if (cur_q == f2_q[MemAw-1:0]) state_d = StDone;
        else cur_d = cur_q + MemAw'(1);
      end
      StRdn: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = cur_q;
        state_d      = StUse;
      end
      StUse: begin
        state_d = StDone;
        case (op_q)
          OpMovMr: abc_d = put_bit(abc_q, dst_q, mrd);
          OpOutMem: begin
            oshift_d = {oshift_q[62:0], mrd};
            ocnt_d   = ocnt_q + 10'd1;
          end
          OpMovMm: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = s1_q[MemAw-1:0];
            mreq.wr_data = mrd;
          end
          OpCopy: begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = dcur_q;
            mreq.wr_data = mrd;
            if (cur_q != f2_q[MemAw-1:0]) begin
              cur_d   = cur_q + MemAw'(1);
              dcur_d  = dcur_q + MemAw'(1);
              state_d = StRdn;
            end
          end
          OpOutRange: begin
            oshift_d = {oshift_q[62:0], mrd};
            ocnt_d   = ocnt_q + 10'd1;
            if (cur_q != f2_q[MemAw-1:0]) begin
              cur_d   = cur_q + MemAw'(1);
              state_d = StRdn;
            end
          end
          OpRet: begin
            ptr_d  = ret_sum[PtrBits-1:0];
            pinv_d = ret_sum[PtrBits];
          end
          default: ;
        endcase
      end
      StDone: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {pcnt_q, pval_q, pr_q, fault_q, stop_q, ptr_q};
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and machine state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      abc_q    <= '0;
      ptr_q    <= '0;
      pinv_q   <= 1'b0;
      oshift_q <= '0;
      ocnt_q   <= '0;
      lvl_q    <= '0;
      stop_q   <= 1'b0;
      fault_q  <= ErrNone;
      plen_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      abc_q    <= abc_d;
      ptr_q    <= ptr_d;
      pinv_q   <= pinv_d;
      oshift_q <= oshift_d;
      ocnt_q   <= ocnt_d;
      lvl_q    <= lvl_d;
      stop_q   <= stop_d;
      fault_q  <= fault_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) plen_q <= cfg_wdata_i;
    end
  end

  // Instruction word, walk pointers and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tdata[4:0];
      src_q <= s_axis_tdata[6:5];
      dst_q <= s_axis_tdata[8:7];
      cb_q  <= s_axis_tdata[9];
      f1_q  <= s_axis_tdata[19:10];
      f2_q  <= s_axis_tdata[29:20];
      s1_q  <= s_axis_tdata[39:30];
      s2_q  <= s_axis_tdata[49:40];
      tgt_q <= s_axis_tdata[65:50];
      off_q <= s_axis_tdata[81:66];
      ib_q  <= s_axis_tdata[82];
    end
    cur_q   <= cur_d;
    dcur_q  <= dcur_d;
    pr_q    <= pr_d;
    pval_q  <= pval_d;
    pcnt_q  <= pcnt_d;
    mdata_q <= mdata_d;
  end

  // Return stack memory with registered read.
  always_ff @(posedge clk_i) begin
    if (st_we) stk_mem[st_waddr] <= ptr_q;
    if (st_re) stk_rdata_q <= stk_mem[st_raddr];
  end

  // The output buffer never grows past its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 10'(OutLimit)) else $error("output buffer count beyond limit");

  // The call stack level never exceeds its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= (StAw+1)'(StackDepth)) else $error("stack level beyond depth");

  // A stopped machine stays stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q) else $error("machine left the stopped state");

  // No word is taken while the bit memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready) else $error("word accepted during clearing");

endmodule
`default_nettype wire

[test/one_bit_cpu_execute_test.sv]
`default_nettype none
module one_bit_cpu_execute_test;
  import ocpu_pkg::*;

  // Opcodes above the last defined one are all unknown.
  localparam logic [4:0] OpFirstUnknown = 5'd29;
  localparam int SelNone = 3;

  typedef struct {
    logic [4:0]         req_type;
    logic [1:0]         src_sel;
    logic [1:0]         dst_sel;
    logic               const_bit;
    logic [9:0]         first_lo;
    logic [9:0]         first_hi;
    logic [9:0]         second_lo;
    logic [9:0]         second_hi;
    logic [15:0]        jump_target;
    logic signed [15:0] jump_offset;
    logic               input_bit;
  } instr_t;

  typedef struct {
    logic [15:0] next_ip;
    logic        halted;
    logic [3:0]  error_code;
    logic        printed;
    logic [63:0] print_value;
    logic [9:0]  print_count;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  one_bit_cpu_execute uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Predicted machine state.
  logic        reg_a, reg_b, reg_c;
  int          ip;
  logic        ip_bad;
  logic        bit_mem [MemBits];
  logic [63:0] out_bits;
  int          out_n;
  logic [15:0] call_stack [StackDepth];
  int          call_depth;
  logic        machine_stopped;
  logic [3:0]  stop_code;
  int          prog_len;

  status_t     status_q [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;
  int          hold_len = 0;

  function automatic logic read_reg(logic [1:0] sel);
    case (sel)
      2'd0: return reg_a;
      2'd1: return reg_b;
      2'd2: return reg_c;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void write_reg(logic [1:0] sel, logic v);
    case (sel)
      2'd0: reg_a = v;
      2'd1: reg_b = v;
      2'd2: reg_c = v;
      default: ;
    endcase
  endfunction

  function automatic void halt_with(logic [3:0] code);
    machine_stopped = 1'b1;
    stop_code = code;
  endfunction

  function automatic void shift_out(logic b);
    out_bits = {out_bits[62:0], b};
    out_n++;
  endfunction

  // Executes one instruction on the predicted state and returns the status word.
  function automatic status_t execute_instr(instr_t w);
    status_t r;
    longint  nxt;
    int      f1, f2, s1, s2, i;
    logic    x, y;
    r = '{default: '0};
    f1 = w.first_lo;
    f2 = w.first_hi;
    s1 = w.second_lo;
    s2 = w.second_hi;
    if (!machine_stopped) begin
      if (ip_bad || ip >= prog_len) begin
        halt_with(ErrPtr);
      end else begin
        nxt = ip + 1;
        case (w.req_type)
          OpMovCr: write_reg(w.dst_sel, w.const_bit);
          OpMovCm: if (f1 >= MemBits) halt_with(ErrAddr); else bit_mem[f1] = w.const_bit;
          OpFill: begin
            if (f1 >= MemBits || f2 >= MemBits) halt_with(ErrAddr);
            else for (i = f1; i <= f2; i++) bit_mem[i] = w.const_bit;
          end
          OpMovMr: if (f1 >= MemBits) halt_with(ErrAddr); else write_reg(w.dst_sel, bit_mem[f1]);
          OpMovRm: if (f1 >= MemBits) halt_with(ErrAddr); else bit_mem[f1] = read_reg(w.src_sel);
          OpMovMm: begin
            if (f1 >= MemBits || s1 >= MemBits) halt_with(ErrAddr);
            else bit_mem[s1] = bit_mem[f1];
          end
          OpCopy: begin
            if (f1 >= MemBits || f2 >= MemBits || s1 >= MemBits || s2 >= MemBits)
              halt_with(ErrAddr);
            else if (f1 > f2 || s1 > s2) halt_with(ErrReversed);
            else if (f2 - f1 != s2 - s1) halt_with(ErrLength);
            else for (i = 0; i <= f2 - f1; i++) bit_mem[s1 + i] = bit_mem[f1 + i];
          end
          OpMovRr: write_reg(w.dst_sel, read_reg(w.src_sel));
          OpJmp: nxt = w.jump_target;
          OpJmpZ: if (w.src_sel != SelNone && !read_reg(w.src_sel)) nxt = w.jump_target;
          OpJmpNz: if (w.src_sel != SelNone && read_reg(w.src_sel)) nxt = w.jump_target;
          OpJmpR: nxt = ip + w.jump_offset;
          OpJmpRz: if (w.src_sel != SelNone && !read_reg(w.src_sel)) nxt = ip + w.jump_offset;
          OpJmpRnz: if (w.src_sel != SelNone && read_reg(w.src_sel)) nxt = ip + w.jump_offset;
          OpAndC: reg_a = reg_a & w.const_bit;
          OpAndR: reg_a = reg_a & read_reg(w.src_sel);
          OpOrC: reg_a = reg_a | w.const_bit;
          OpOrR: reg_a = reg_a | read_reg(w.src_sel);
          OpNot: reg_a = ~reg_a;
          OpSwap: begin
            x = read_reg(w.src_sel);
            y = read_reg(w.dst_sel);
            write_reg(w.src_sel, y);
            write_reg(w.dst_sel, x);
          end
          OpOutA: if (out_n >= OutLimit) halt_with(ErrOverflow); else shift_out(reg_a);
          OpOutMem: begin
            if (out_n >= OutLimit) halt_with(ErrOverflow);
            else if (f1 >= MemBits) halt_with(ErrAddr);
            else shift_out(bit_mem[f1]);
          end
          OpOutRange: begin
            if (f1 >= MemBits || f2 >= MemBits) halt_with(ErrAddr);
            else if (f1 > f2) halt_with(ErrReversed);
            else if (out_n + f2 - f1 + 1 > OutLimit) halt_with(ErrOverflow);
            else for (i = f1; i <= f2; i++) shift_out(bit_mem[i]);
          end
          OpPrint: begin
            r.printed = 1'b1;
            r.print_value = out_bits;
            r.print_count = 10'(out_n);
            out_bits = '0;
            out_n = 0;
          end
          OpHalt: halt_with(ErrNone);
          OpInA: reg_a = w.input_bit;
          OpInMem: if (f1 >= MemBits) halt_with(ErrAddr); else bit_mem[f1] = w.input_bit;
          OpCall: begin
            if (call_depth >= StackDepth) halt_with(ErrStackOvf);
            else begin
              call_stack[call_depth] = ip;
              call_depth++;
              nxt = w.jump_target;
            end
          end
          OpRet: begin
            if (call_depth == 0) halt_with(ErrStackEmp);
            else begin
              call_depth--;
              nxt = call_stack[call_depth] + 1;
            end
          end
          default: halt_with(ErrUnknown);
        endcase
        if (!(machine_stopped && stop_code != ErrNone)) begin
          ip_bad = (nxt < 0 || nxt >= (64'd1 << PtrBits));
          ip = int'(nxt & 64'hFFFF);
        end
      end
    end
    r.next_ip = ip;
    r.halted = machine_stopped;
    r.error_code = stop_code;
    return r;
  endfunction

  function automatic int rand_span();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, MemBits - 1);
    return $urandom_range(0, 15);
  endfunction

  // Builds an instruction with random content that cannot stop the machine,
  // given the predicted state at the moment it is sent.
  function automatic instr_t legal_instr(logic [4:0] op);
    instr_t w;
    int     l, lo, hi, dest;
    w.src_sel = $urandom_range(0, 3);
    w.dst_sel = $urandom_range(0, 3);
    w.const_bit = $urandom_range(0, 1);
    w.first_lo = $urandom;
    w.first_hi = $urandom;
    w.second_lo = $urandom;
    w.second_hi = $urandom;
    w.jump_target = $urandom;
    w.jump_offset = $urandom;
    w.input_bit = $urandom_range(0, 1);
    if (op == OpRet && (call_depth == 0 || call_stack[call_depth - 1] + 1 >= prog_len))
      op = (call_depth < StackDepth) ? OpCall : OpJmp;
    if (op == OpCall && call_depth >= StackDepth) op = OpJmp;
    if ((op == OpOutA || op == OpOutMem || op == OpOutRange) && out_n >= OutLimit) op = OpPrint;
    if (ip + 1 >= prog_len && op != OpRet) op = OpJmp;
    if (op >= OpHalt && op != OpInA && op != OpInMem && op != OpCall && op != OpRet) op = OpPrint;
    w.req_type = op;
    case (op)
      OpMovCm, OpMovMr, OpMovRm, OpOutMem, OpInMem: w.first_lo = $urandom_range(0, MemBits - 1);
      OpMovMm: begin
        w.first_lo = $urandom_range(0, MemBits - 1);
        w.second_lo = $urandom_range(0, MemBits - 1);
      end
      OpFill: begin
        if ($urandom_range(0, 7) == 0) begin
          w.first_lo = $urandom_range(1, MemBits - 1);
          w.first_hi = $urandom_range(0, w.first_lo - 1);
        end else begin
          l = rand_span();
          w.first_lo = $urandom_range(0, MemBits - 1 - l);
          w.first_hi = w.first_lo + l;
        end
      end
      OpCopy: begin
        l = rand_span();
        w.first_lo = $urandom_range(0, MemBits - 1 - l);
        w.first_hi = w.first_lo + l;
        w.second_lo = $urandom_range(0, MemBits - 1 - l);
        w.second_hi = w.second_lo + l;
      end
      OpOutRange: begin
        l = rand_span();
        if (out_n + l + 1 > OutLimit) l = OutLimit - out_n - 1;
        w.first_lo = $urandom_range(0, MemBits - 1 - l);
        w.first_hi = w.first_lo + l;
      end
      OpJmp, OpJmpZ, OpJmpNz, OpCall: w.jump_target = $urandom_range(0, prog_len - 1);
      OpJmpR, OpJmpRz, OpJmpRnz: begin
        lo = (ip > 32768) ? ip - 32768 : 0;
        hi = (ip + 32767 < prog_len - 1) ? ip + 32767 : prog_len - 1;
        dest = $urandom_range(lo, hi);
        w.jump_offset = dest - ip;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic instr_t noise_instr();
    instr_t w;
    w = legal_instr(OpPrint);
    w.req_type = $urandom;
    w.src_sel = $urandom;
    w.dst_sel = $urandom;
    return w;
  endfunction

  // Sends one word with burst and gap idling; prediction is made on acceptance.
  task automatic send_word(instr_t w);
    status_t predicted;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tdata = {5'b0, w.input_bit, w.jump_offset, w.jump_target, w.second_hi,
                    w.second_lo, w.first_hi, w.first_lo, w.const_bit, w.dst_sel,
                    w.src_sel, w.req_type};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = execute_instr(w);
    status_q.insert(status_q.size(), predicted);
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_legal(logic [4:0] op);
    send_word(legal_instr(op));
  endtask

  task automatic wait_idle();
    wait (status_q.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_length(int v);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    prog_len = v;
  endtask

  // Receiver stall pattern; a requested hold-off overrides it for a counted stretch.
  int ready_mode = 0;
  int hold_cycles = 0;
  int mode_cycles = 0;
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_cycles = hold_len;
      hold_request = 1'b0;
    end
    if (mode_cycles == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_cycles = $urandom_range(50, 300);
    end
    mode_cycles--;
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready = 1'b0;
    end else begin
      case (ready_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = $urandom_range(0, 1);
        default: m_axis_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compares each status word with the oldest prediction.
  always @(posedge clk_i) begin
    status_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.next_ip = m_axis_tdata[15:0];
      got.halted = m_axis_tdata[16];
      got.error_code = m_axis_tdata[20:17];
      got.printed = m_axis_tdata[21];
      got.print_value = m_axis_tdata[85:22];
      got.print_count = m_axis_tdata[95:86];
      if (status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected status word %h", m_axis_tdata);
      end else begin
        want = status_q.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected ip %0d halt %0d err %0d prt %0d val %h cnt %0d, got ip %0d halt %0d err %0d prt %0d val %h cnt %0d",
                     want.next_ip, want.halted, want.error_code, want.printed,
                     want.print_value, want.print_count, got.next_ip, got.halted,
                     got.error_code, got.printed, got.print_value, got.print_count);
        end
      end
    end
  end

  // Every opcode but halt once, then the field extremes and the corner cases.
  task automatic test_each_opcode();
    instr_t w;
    for (int op = 0; op <= OpRet; op++)
      if (op != OpHalt) send_legal(op);
    w = legal_instr(OpFill);
    w.first_lo = 0;
    w.first_hi = MemBits - 1;
    w.const_bit = 1'b1;
    send_word(w);
    w = legal_instr(OpCopy);
    w.first_lo = 0;
    w.first_hi = 9;
    w.second_lo = 1;
    w.second_hi = 10;
    send_word(w);
    send_legal(OpPrint);
    w = legal_instr(OpOutRange);
    w.first_lo = MemBits - 100;
    w.first_hi = MemBits - 1;
    send_word(w);
    send_legal(OpPrint);
    w = legal_instr(OpJmpNz);
    w.src_sel = SelNone;
    send_word(w);
  endtask

  task automatic test_random_program(int n);
    int op;
    repeat (n) begin
      op = $urandom_range(0, 27);
      if (op >= OpHalt) op++;
      send_legal(op);
    end
  endtask

  // Program length at its largest, at one, and at random values above the pointer.
  task automatic test_length_settings();
    instr_t w;
    w = legal_instr(OpJmp);
    w.req_type = OpJmp;
    w.jump_target = 0;
    send_word(w);
    set_length(1);
    test_random_program(6);
    set_length(16'hFFFF);
    test_random_program(100);
    set_length($urandom_range(ip + 1, 16'hFFFF));
    test_random_program(100);
    set_length($urandom_range(ip + 1, ip + 40));
    test_random_program(100);
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    hold_request = 1'b1;
    test_random_program(15);
    wait_idle();
    test_random_program(150);
  endtask

  // Ends the program one way or another; afterwards every word is ignored.
  task automatic test_terminal_stop();
    instr_t w;
    int     kind;
    set_length(16'hFFFF);
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        w = legal_instr(OpPrint);
        w.req_type = OpHalt;
        send_word(w);
      end
      1: set_length(0);
      2: begin
        w = legal_instr(OpMovMm);
        w.second_lo = $urandom_range(MemBits, 1023);
        send_word(w);
      end
      3: begin
        w = legal_instr(OpCopy);
        w.first_lo = 20;
        w.first_hi = 10;
        send_word(w);
      end
      4: begin
        w = legal_instr(OpCopy);
        w.second_hi = w.second_hi + 1;
        send_word(w);
      end
      5: while (!machine_stopped && out_n < OutLimit) send_legal(OpOutRange);
      6: while (!machine_stopped && call_depth < StackDepth) send_legal(OpCall);
      7: while (!machine_stopped && call_depth > 0) send_legal(OpRet);
      8: begin
        w = legal_instr(OpPrint);
        w.req_type = $urandom_range(OpFirstUnknown, 31);
        send_word(w);
      end
      default: begin
        w = legal_instr(OpJmpR);
        w.req_type = OpJmpR;
        w.jump_offset = -ip - $urandom_range(1, 100);
        send_word(w);
      end
    endcase
    case (kind)
      5: begin
        w = legal_instr(OpPrint);
        w.req_type = OpOutA;
        send_word(w);
      end
      6: begin
        w = legal_instr(OpPrint);
        w.req_type = OpCall;
        send_word(w);
      end
      7: begin
        w = legal_instr(OpPrint);
        w.req_type = OpRet;
        send_word(w);
      end
      default: ;
    endcase
    repeat (12) send_word(noise_instr());
  endtask

  initial begin
    reg_a = 0;
    reg_b = 0;
    reg_c = 0;
    ip = 0;
    ip_bad = 0;
    foreach (bit_mem[i]) bit_mem[i] = 1'b0;
    out_bits = '0;
    out_n = 0;
    foreach (call_stack[i]) call_stack[i] = '0;
    call_depth = 0;
    machine_stopped = 0;
    stop_code = ErrNone;
    prog_len = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    set_length(16'hFFFF);
    test_each_opcode();
    test_length_settings();
    test_backpressure();
    set_length(16'hFFFF);
    test_random_program(130);
    test_terminal_stop();
    wait (status_q.size() == 0);
    repeat (1200) @(negedge clk_i);
    if (mismatch_count == 0 && status_q.size() == 0)
      $display("one_bit_cpu_execute_test: PASS");
    else
      $display("one_bit_cpu_execute_test: FAIL");
    $finish;
  end

  initial begin
    #50000000;
    $display("one_bit_cpu_execute_test: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/ocpu_pkg.sv
rtl/ocpu_bitmem.sv
rtl/one_bit_cpu_execute.sv
test/one_bit_cpu_execute_test.sv
